// ===== hdl/pppc_pkg.sv =====
// shared types and constants for the pinhole point projector
// no dependencies; used by pppc_xform, pppc_div and the top level
package pppc_pkg;

  // datapath widths
  localparam int CoordW = 16;   // point and coefficient entries
  localparam int VecW   = 35;   // camera-frame vector after rotation and translation
  localparam int MagW   = 53;   // homogeneous image coordinates
  localparam int NumW   = 69;   // scaled numerator
  localparam int DenW   = 61;   // denominator times 256
  localparam int QuoW   = 17;   // quotient bits resolved by the divider

  // pipeline depth from input register to last datapath stage
  localparam int XformLat = 5;
  localparam int DivLat   = 3 + QuoW + 1;
  localparam int PipeLat  = XformLat + DivLat;

  // configuration register indexes
  localparam logic [2:0] RegRot0  = 3'd0;
  localparam logic [2:0] RegRot1  = 3'd1;
  localparam logic [2:0] RegRot2  = 3'd2;
  localparam logic [2:0] RegTrans = 3'd3;
  localparam logic [2:0] RegIntr0 = 3'd4;
  localparam logic [2:0] RegIntr1 = 3'd5;
  localparam logic [2:0] RegIntr2 = 3'd6;
  localparam logic [2:0] RegScale = 3'd7;

  localparam logic [15:0] ScaleReset = 16'd256;

  // transform result handed to the dividers
  typedef struct packed {
    logic [MagW-1:0] mag_col;
    logic [MagW-1:0] mag_row;
    logic [MagW-1:0] mag_den;
    logic            neg_col;
    logic            neg_row;
    logic            zero;
  } xform_t;

endpackage

// ===== hdl/pinhole_point_projector_core.sv =====
// pinhole point projector: one point per cycle sustained while in_stall_o is low,
// through a fully pipelined datapath (5 transform stages, 21 divider stages) and
// a 17-stage restoring divider per coordinate.
// an output register plus skid register keep input open while one result waits.
// reset clears valid bits and loads configuration defaults (scale 1.0, rest 0).
// depends on pppc_pkg, pppc_xform, pppc_div
module pinhole_point_projector_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] point_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pixel_col_o,
  output logic signed [15:0] pixel_row_o,
  output logic               zero_depth_o
);

  localparam int Lat = pppc_pkg::PipeLat;

  logic [2:0][47:0] rot_q, intr_q;
  logic [47:0]      trans_q;
  logic [15:0]      scale_q;

  logic             en;
  logic [Lat-1:0]   vld_q;
  pppc_pkg::xform_t xf;
  logic signed [15:0] col, row;
  logic             zero_col, zero_row;
  logic             push, take;

  logic               out_v_q, skid_v_q;
  logic signed [15:0] out_col_q, out_row_q, skid_col_q, skid_row_q;
  logic               out_zero_q, skid_zero_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q   <= '0;
      intr_q  <= '0;
      trans_q <= '0;
      scale_q <= pppc_pkg::ScaleReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pppc_pkg::RegRot0:  rot_q[0]  <= cfg_data_i;
        pppc_pkg::RegRot1:  rot_q[1]  <= cfg_data_i;
        pppc_pkg::RegRot2:  rot_q[2]  <= cfg_data_i;
        pppc_pkg::RegTrans: trans_q   <= cfg_data_i;
        pppc_pkg::RegIntr0: intr_q[0] <= cfg_data_i;
        pppc_pkg::RegIntr1: intr_q[1] <= cfg_data_i;
        pppc_pkg::RegIntr2: intr_q[2] <= cfg_data_i;
        pppc_pkg::RegScale: scale_q   <= cfg_data_i[15:0];
      endcase
    end
  end

  // pipeline moves unless the skid register is occupied
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // valid bits alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  pppc_xform u_xform (
    .clk_i     (clk_i),
    .en_i      (en),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .rot_i     (rot_q),
    .trans_i   (trans_q),
    .intr_i    (intr_q),
    .xf_o      (xf)
  );

  pppc_div u_div_col (
    .clk_i   (clk_i),
    .en_i    (en),
    .scale_i (scale_q),
    .num_i   (xf.mag_col),
    .den_i   (xf.mag_den),
    .neg_i   (xf.neg_col),
    .zero_i  (xf.zero),
    .coord_o (col),
    .zero_o  (zero_col)
  );

  pppc_div u_div_row (
    .clk_i   (clk_i),
    .en_i    (en),
    .scale_i (scale_q),
    .num_i   (xf.mag_row),
    .den_i   (xf.mag_den),
    .neg_i   (xf.neg_row),
    .zero_i  (xf.zero),
    .coord_o (row),
    .zero_o  (zero_row)
  );

  assign push = vld_q[Lat-1] && en;
  assign take = out_v_q && !out_stall_i;

  // output register and skid register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || take) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      if (skid_v_q) begin
        out_col_q  <= skid_col_q;
        out_row_q  <= skid_row_q;
        out_zero_q <= skid_zero_q;
      end else begin
        out_col_q  <= col;
        out_row_q  <= row;
        out_zero_q <= zero_col & zero_row;
      end
    end else if (push) begin
      skid_col_q  <= col;
      skid_row_q  <= row;
      skid_zero_q <= zero_col & zero_row;
    end
  end

  assign out_valid_o  = out_v_q;
  assign pixel_col_o  = out_col_q;
  assign pixel_row_o  = out_row_q;
  assign zero_depth_o = out_zero_q;

endmodule

// ===== hdl/pppc_xform.sv =====
// rotation, translation and intrinsic matrix stages of the projector
// depends on pppc_pkg
module pppc_xform (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [15:0]  point_x_i,
  input  logic signed [15:0]  point_y_i,
  input  logic signed [15:0]  point_z_i,
  input  logic [2:0][47:0]    rot_i,
  input  logic [47:0]         trans_i,
  input  logic [2:0][47:0]    intr_i,
  output pppc_pkg::xform_t    xf_o
);

  logic signed [15:0] pt [3];
  logic signed [31:0] rp_q [3][3];
  logic signed [29:0] t_q [3];
  logic signed [pppc_pkg::VecW-1:0] v_q [3];
  logic signed [50:0] kv_q [3][3];
  logic signed [pppc_pkg::MagW-1:0] m_q [3];
  pppc_pkg::xform_t xf_q;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  // stage 1: rotation products, translation aligned to Q.14
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rp_q[i][j] <= $signed(rot_i[i][16*j +: 16]) * pt[j];
        end
        t_q[i] <= {$signed(trans_i[16*i +: 16]), 14'b0};
      end
    end
  end

  // stage 2: row sums minus translation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= pppc_pkg::VecW'(rp_q[i][0]) + pppc_pkg::VecW'(rp_q[i][1])
                + pppc_pkg::VecW'(rp_q[i][2]) - pppc_pkg::VecW'(t_q[i]);
      end
    end
  end

  // stage 3: intrinsic products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          kv_q[i][j] <= $signed(intr_i[i][16*j +: 16]) * v_q[j];
        end
      end
    end
  end

  // stage 4: intrinsic row sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m_q[i] <= pppc_pkg::MagW'(kv_q[i][0]) + pppc_pkg::MagW'(kv_q[i][1])
                + pppc_pkg::MagW'(kv_q[i][2]);
      end
    end
  end

  // stage 5: magnitudes, result signs and zero denominator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xf_q.mag_col <= m_q[0][pppc_pkg::MagW-1] ? pppc_pkg::MagW'(-m_q[0]) : m_q[0];
      xf_q.mag_row <= m_q[1][pppc_pkg::MagW-1] ? pppc_pkg::MagW'(-m_q[1]) : m_q[1];
      xf_q.mag_den <= m_q[2][pppc_pkg::MagW-1] ? pppc_pkg::MagW'(-m_q[2]) : m_q[2];
      xf_q.neg_col <= m_q[0][pppc_pkg::MagW-1] ^ m_q[2][pppc_pkg::MagW-1];
      xf_q.neg_row <= m_q[1][pppc_pkg::MagW-1] ^ m_q[2][pppc_pkg::MagW-1];
      xf_q.zero    <= (m_q[2] == '0);
    end
  end

  assign xf_o = xf_q;

endmodule

// ===== hdl/pppc_div.sv =====
// scaled divide for one image coordinate: scale multiply, restoring divider,
// sign and saturation; depends on pppc_pkg
module pppc_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [15:0]               scale_i,
  input  logic [pppc_pkg::MagW-1:0] num_i,
  input  logic [pppc_pkg::MagW-1:0] den_i,
  input  logic                      neg_i,
  input  logic                      zero_i,
  output logic signed [15:0]        coord_o,
  output logic                      zero_o
);

  localparam int QB = pppc_pkg::QuoW;
  localparam int NW = pppc_pkg::NumW;
  localparam int DW = pppc_pkg::DenW;
  localparam int CW = DW + QB;

  logic [42:0]         plo_q;
  logic [41:0]         phi_q;
  logic [pppc_pkg::MagW-1:0] den6_q;
  logic                neg6_q, zero6_q;
  logic [NW-1:0]       n7_q;
  logic [DW-1:0]       d7_q;
  logic                neg7_q, zero7_q;

  logic [NW-1:0]       r_q   [QB+1];
  logic [QB-1:0]       quo_q [QB+1];
  logic [DW-1:0]       d_q   [QB+1];
  logic                ovf_q [QB+1];
  logic                neg_q [QB+1];
  logic                zr_q  [QB+1];

  logic signed [15:0]  coord_q;
  logic                zero_q;

  // scale times numerator as two partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q   <= scale_i * num_i[26:0];
      phi_q   <= scale_i * num_i[pppc_pkg::MagW-1:27];
      den6_q  <= den_i;
      neg6_q  <= neg_i;
      zero6_q <= zero_i;
    end
  end

  // combine partial products, denominator times 256
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n7_q    <= (NW'(phi_q) << 27) + NW'(plo_q);
      d7_q    <= {den6_q, 8'b0};
      neg7_q  <= neg6_q;
      zero7_q <= zero6_q;
    end
  end

  // quotient overflow check, divider setup
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= n7_q;
      quo_q[0] <= '0;
      d_q[0]   <= d7_q;
      ovf_q[0] <= (CW'(n7_q) >= {d7_q, QB'(0)});
      neg_q[0] <= neg7_q;
      zr_q[0]  <= zero7_q;
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int K = QB - 1 - s;
    logic [CW-1:0] dsh;
    logic          ge;
    assign dsh = CW'(d_q[s]) << K;
    assign ge  = CW'(r_q[s]) >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]   <= ge ? NW'(CW'(r_q[s]) - dsh) : r_q[s];
        quo_q[s+1] <= {quo_q[s][QB-2:0], ge};
        d_q[s+1]   <= d_q[s];
        ovf_q[s+1] <= ovf_q[s];
        neg_q[s+1] <= neg_q[s];
        zr_q[s+1]  <= zr_q[s];
      end
    end
  end

  // sign, saturation, zero denominator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= zr_q[QB];
      priority if (zr_q[QB]) begin
        coord_q <= '0;
      end else if (neg_q[QB]) begin
        if (ovf_q[QB] || quo_q[QB] > QB'(32768)) coord_q <= 16'sh8000;
        else coord_q <= 16'(-quo_q[QB]);
      end else begin
        if (ovf_q[QB] || quo_q[QB] > QB'(32767)) coord_q <= 16'sh7fff;
        else coord_q <= 16'(quo_q[QB]);
      end
    end
  end

  assign coord_o = coord_q;
  assign zero_o  = zero_q;

endmodule
